// ===== sv/evd_pkg.sv =====
// Shared types, constants and helper functions for the event record deframer.
// Depends on nothing; used by event_record_deframer.
`default_nettype none

package evd_pkg;

  localparam int WordWidth   = 32;
  localparam int StatusWidth = 3;
  localparam int FifoDepth   = 8;
  localparam int FifoAw      = $clog2(FifoDepth);
  localparam int HeaderWords = 4;

  // Room that must be free before a word is taken: one word can queue a whole header.
  localparam int AcceptLimit = FifoDepth - HeaderWords;

  localparam logic [WordWidth-1:0] HalfMask = 32'hffff_0000;

  // Result status codes.
  localparam logic [StatusWidth-1:0] ST_DATA        = 3'd0;
  localparam logic [StatusWidth-1:0] ST_TOO_BIG     = 3'd1;
  localparam logic [StatusWidth-1:0] ST_OVER_EXPECT = 3'd2;
  localparam logic [StatusWidth-1:0] ST_INCOMPLETE  = 3'd3;
  localparam logic [StatusWidth-1:0] ST_BELOW_THREE = 3'd4;
  localparam logic [StatusWidth-1:0] ST_END         = 3'd5;

  // Byte order remembered from the previous record.
  localparam logic [1:0] ORDER_UNKNOWN = 2'd0;
  localparam logic [1:0] ORDER_NATIVE  = 2'd1;
  localparam logic [1:0] ORDER_SWAPPED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_EVENT_WORDS = 2'd0;
  localparam logic [1:0] REG_MAX_EXPECT      = 2'd1;
  localparam logic [1:0] REG_EXPECT_IS_ERROR = 2'd2;

  localparam logic [WordWidth-1:0] MaxEventWordsReset = 32'd65536;

  typedef struct packed {
    logic [WordWidth-1:0]   out_word;
    logic                   first_of_record;
    logic                   last_of_record;
    logic                   was_swapped;
    logic                   order_changed;
    logic                   expect_warning;
    logic [StatusWidth-1:0] status;
  } result_t;

  function automatic logic [WordWidth-1:0] bswap32(input logic [WordWidth-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/event_record_deframer.sv =====
// Event record deframer top level: header hold, byte-order decision, size checks
// and the result queue. Depends on evd_pkg.
`default_nettype none

// Takes one 32-bit stream word per cycle when s_tready is high. The first three words
// of a record are held; the fourth decides the byte order and releases all four header
// words at once (only the size word on a size error) into an eight-entry result queue,
// which drains one word per cycle when m_tready is high. Body words pass through the
// same queue. s_tready falls only while more than four results are queued, so with a
// free-running master side it sustains one word per cycle across records of any size.
// After a fatal error or an end-of-data marker it takes and discards words until reset.
module event_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // [31:0] data_word
  input  wire logic        s_tuser,    // [0] end_of_data
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,    // [31:0] out_word
  output logic             m_tlast,    // last_of_record
  output logic [7:0]       m_tuser,    // [0] first_of_record, [1] was_swapped,
                                       // [2] order_changed, [3] expect_warning,
                                       // [6:4] status, [7] zero
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int Aw = evd_pkg::FifoAw;

  // Configuration registers.
  logic [31:0] max_event_words;
  logic [31:0] max_expect;
  logic        expect_is_error;

  // Deframer state.
  logic [31:0] header_store [3];
  logic [1:0]  header_index, header_index_next;
  logic [31:0] words_remaining, words_remaining_next;
  logic        swap_current, swap_current_next;
  logic [1:0]  last_order, last_order_next;
  logic        stopped, stopped_next;

  logic        store_we;

  // Result queue.
  evd_pkg::result_t fifo [evd_pkg::FifoDepth];
  logic [Aw-1:0]    wr_ptr;
  logic [Aw-1:0]    rd_ptr;
  logic [Aw:0]      count;
  logic [2:0]       push_count;
  evd_pkg::result_t push_entry [evd_pkg::HeaderWords];

  logic in_xfer;
  logic out_xfer;

  // Header decision signals.
  logic [31:0] h_raw [evd_pkg::HeaderWords];
  logic [31:0] h_fix [evd_pkg::HeaderWords];
  logic        sw;
  logic [1:0]  order;
  logic        changed;
  logic [31:0] size;
  logic        too_big;
  logic        over_expect;
  logic        below_three;
  logic        rest_zero;

  assign cfg_ready = 1'b1;
  assign s_tready  = stopped || (count <= (Aw+1)'(evd_pkg::AcceptLimit));
  assign in_xfer   = s_tvalid && s_tready;
  assign m_tvalid  = (count != '0);
  assign out_xfer  = m_tvalid && m_tready;

  assign m_tdata = fifo[rd_ptr].out_word;
  assign m_tlast = fifo[rd_ptr].last_of_record;
  assign m_tuser = {1'b0, fifo[rd_ptr].status, fifo[rd_ptr].expect_warning,
                    fifo[rd_ptr].order_changed, fifo[rd_ptr].was_swapped,
                    fifo[rd_ptr].first_of_record};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_event_words <= evd_pkg::MaxEventWordsReset;
      max_expect      <= '0;
      expect_is_error <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        evd_pkg::REG_MAX_EVENT_WORDS: max_event_words <= cfg_data;
        evd_pkg::REG_MAX_EXPECT:      max_expect      <= cfg_data;
        evd_pkg::REG_EXPECT_IS_ERROR: expect_is_error <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Byte order is set by word 3 unless it is zero, then by the size word.
  always_comb begin
    h_raw[0] = header_store[0];
    h_raw[1] = header_store[1];
    h_raw[2] = header_store[2];
    h_raw[3] = s_tdata;
    if (s_tdata == '0) begin
      sw = ((header_store[0] & evd_pkg::HalfMask) != '0);
    end else begin
      sw = ((s_tdata & evd_pkg::HalfMask) != '0);
    end
    for (int i = 0; i < evd_pkg::HeaderWords; i++) begin
      h_fix[i] = sw ? evd_pkg::bswap32(h_raw[i]) : h_raw[i];
    end
    order       = sw ? evd_pkg::ORDER_SWAPPED : evd_pkg::ORDER_NATIVE;
    changed     = (last_order != evd_pkg::ORDER_UNKNOWN) && (last_order != order);
    size        = h_fix[0];
    too_big     = (size > max_event_words);
    over_expect = (max_expect != '0) && (size > max_expect);
    below_three = (size < 32'd3);
    rest_zero   = (size == 32'd3);
  end

  always_comb begin
    header_index_next    = header_index;
    words_remaining_next = words_remaining;
    swap_current_next    = swap_current;
    last_order_next      = last_order;
    stopped_next         = stopped;
    store_we             = 1'b0;
    push_count           = '0;
    for (int i = 0; i < evd_pkg::HeaderWords; i++) begin
      push_entry[i] = '0;
    end

    if (in_xfer && !stopped) begin
      if (s_tuser) begin
        push_count           = 3'd1;
        push_entry[0].status = ((header_index != '0) || (words_remaining != '0))
                               ? evd_pkg::ST_INCOMPLETE : evd_pkg::ST_END;
        stopped_next         = 1'b1;
      end else if (words_remaining != '0) begin
        words_remaining_next           = words_remaining - 32'd1;
        push_count                     = 3'd1;
        push_entry[0].out_word         = swap_current ? evd_pkg::bswap32(s_tdata) : s_tdata;
        push_entry[0].last_of_record   = (words_remaining == 32'd1);
        push_entry[0].was_swapped      = swap_current;
        push_entry[0].status           = evd_pkg::ST_DATA;
      end else if (header_index != 2'd3) begin
        store_we          = 1'b1;
        header_index_next = header_index + 2'd1;
      end else begin
        header_index_next             = '0;
        last_order_next               = order;
        swap_current_next             = sw;
        push_entry[0].out_word        = size;
        push_entry[0].first_of_record = 1'b1;
        push_entry[0].was_swapped     = sw;
        push_entry[0].order_changed   = changed;
        priority if (too_big) begin
          push_count           = 3'd1;
          push_entry[0].status = evd_pkg::ST_TOO_BIG;
          stopped_next         = 1'b1;
        end else if (over_expect && expect_is_error) begin
          push_count           = 3'd1;
          push_entry[0].status = evd_pkg::ST_OVER_EXPECT;
          stopped_next         = 1'b1;
        end else if (below_three) begin
          push_count                   = 3'd1;
          push_entry[0].expect_warning = over_expect;
          push_entry[0].status         = evd_pkg::ST_BELOW_THREE;
          stopped_next                 = 1'b1;
        end else begin
          push_count                   = 3'(evd_pkg::HeaderWords);
          push_entry[0].expect_warning = over_expect;
          push_entry[0].status         = evd_pkg::ST_DATA;
          words_remaining_next         = size - 32'd3;
          for (int i = 1; i < evd_pkg::HeaderWords; i++) begin
            push_entry[i].out_word    = h_fix[i];
            push_entry[i].was_swapped = sw;
            push_entry[i].status      = evd_pkg::ST_DATA;
          end
          push_entry[3].last_of_record = rest_zero;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index    <= '0;
      words_remaining <= '0;
      swap_current    <= 1'b0;
      last_order      <= evd_pkg::ORDER_UNKNOWN;
      stopped         <= 1'b0;
    end else begin
      header_index    <= header_index_next;
      words_remaining <= words_remaining_next;
      swap_current    <= swap_current_next;
      last_order      <= last_order_next;
      stopped         <= stopped_next;
    end
  end

  // Header words are held without reset; each is written before it is read.
  always_ff @(posedge clk) begin
    if (store_we) begin
      unique case (header_index)
        2'd0:    header_store[0] <= s_tdata;
        2'd1:    header_store[1] <= s_tdata;
        default: header_store[2] <= s_tdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < evd_pkg::HeaderWords; k++) begin
      if (3'(k) < push_count) begin
        fifo[wr_ptr + Aw'(k)] <= push_entry[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count[Aw-1:0];
      if (out_xfer) begin
        rd_ptr <= rd_ptr + Aw'(1);
      end
      count <= count + (Aw+1)'(push_count) - (Aw+1)'(out_xfer);
    end
  end

endmodule

`default_nettype wire

// ===== dv/evd_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the event record deframer: watches the input, output and configuration
// transfers, predicts each record word and compares it field by field. Depends on evd_pkg.

module evd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic [7:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          pending,
  output int          checked
);

  evd_pkg::result_t expected_words[$];

  // Predicted block state.
  logic [31:0] hdr [0:2];
  logic [1:0]  hdr_count;
  logic [31:0] body_left;
  logic        body_swapped;
  logic [1:0]  prev_order;
  logic        halted;

  // Predicted register contents.
  logic [31:0] lim_words;
  logic [31:0] lim_expect;
  logic        expect_fatal;

  int mismatches = 0;
  int matched = 0;

  function automatic logic [31:0] reverse_bytes(input logic [31:0] w);
    reverse_bytes = {<<8{w}};
  endfunction

  task automatic deframe_word(input logic [31:0] w, input logic eod);
    evd_pkg::result_t r;
    logic [31:0] hw [0:3];
    logic        swap;
    logic [1:0]  order;
    logic        changed;
    logic        warn;
    logic [31:0] size;
    if (halted) return;
    r = '0;
    if (eod) begin
      r.status = (hdr_count != 0 || body_left != 0) ? evd_pkg::ST_INCOMPLETE
                                                      : evd_pkg::ST_END;
      expected_words.push_back(r);
      halted = 1'b1;
      return;
    end
    if (body_left != 0) begin
      body_left = body_left - 1;
      r.out_word = body_swapped ? reverse_bytes(w) : w;
      r.last_of_record = (body_left == 0);
      r.was_swapped = body_swapped;
      r.status = evd_pkg::ST_DATA;
      expected_words.push_back(r);
      return;
    end
    if (hdr_count < 3) begin
      hdr[hdr_count] = w;
      hdr_count = hdr_count + 2'd1;
      return;
    end

    // Fourth header word: word 3 decides the order unless it is zero.
    hdr_count = '0;
    hw[0] = hdr[0];
    hw[1] = hdr[1];
    hw[2] = hdr[2];
    hw[3] = w;
    swap = (w == 0) ? |(hdr[0] & evd_pkg::HalfMask) : |(w & evd_pkg::HalfMask);
    order = swap ? evd_pkg::ORDER_SWAPPED : evd_pkg::ORDER_NATIVE;
    changed = (prev_order != evd_pkg::ORDER_UNKNOWN) && (prev_order != order);
    prev_order = order;
    body_swapped = swap;
    if (swap) begin
      for (int i = 0; i < 4; i++) hw[i] = reverse_bytes(hw[i]);
    end
    size = hw[0];

    r.out_word = size;
    r.first_of_record = 1'b1;
    r.was_swapped = swap;
    r.order_changed = changed;
    warn = 1'b0;
    if (size > lim_words) begin
      r.status = evd_pkg::ST_TOO_BIG;
      expected_words.push_back(r);
      halted = 1'b1;
      return;
    end
    if (lim_expect != 0 && size > lim_expect) begin
      if (expect_fatal) begin
        r.status = evd_pkg::ST_OVER_EXPECT;
        expected_words.push_back(r);
        halted = 1'b1;
        return;
      end
      warn = 1'b1;
    end
    if (size < 3) begin
      r.expect_warning = warn;
      r.status = evd_pkg::ST_BELOW_THREE;
      expected_words.push_back(r);
      halted = 1'b1;
      return;
    end

    body_left = size - 3;
    for (int i = 0; i < 4; i++) begin
      r = '0;
      r.out_word = hw[i];
      r.first_of_record = (i == 0);
      r.last_of_record = (i == 3) && (body_left == 0);
      r.was_swapped = swap;
      r.order_changed = (i == 0) ? changed : 1'b0;
      r.expect_warning = (i == 0) ? warn : 1'b0;
      r.status = evd_pkg::ST_DATA;
      expected_words.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic match_result();
    evd_pkg::result_t r;
    if (expected_words.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected transfer, expected nothing, actual data %h last %b user %h",
               $time, m_tdata, m_tlast, m_tuser);
      return;
    end
    r = expected_words.pop_front();
    compare_field("out_word", r.out_word, m_tdata);
    compare_field("first_of_record", 32'(r.first_of_record), 32'(m_tuser[0]));
    compare_field("last_of_record", 32'(r.last_of_record), 32'(m_tlast));
    compare_field("was_swapped", 32'(r.was_swapped), 32'(m_tuser[1]));
    compare_field("order_changed", 32'(r.order_changed), 32'(m_tuser[2]));
    compare_field("expect_warning", 32'(r.expect_warning), 32'(m_tuser[3]));
    compare_field("status", 32'(r.status), 32'(m_tuser[6:4]));
    compare_field("tuser pad bit", 32'd0, 32'(m_tuser[7]));
    matched++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      hdr_count = '0;
      body_left = '0;
      body_swapped = 1'b0;
      prev_order = evd_pkg::ORDER_UNKNOWN;
      halted = 1'b0;
      lim_words = evd_pkg::MaxEventWordsReset;
      lim_expect = '0;
      expect_fatal = 1'b0;
    end else begin
      // Registers must change only while idle (unenforced); then order vs streams is free.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          evd_pkg::REG_MAX_EVENT_WORDS: lim_words = cfg_data;
          evd_pkg::REG_MAX_EXPECT:      lim_expect = cfg_data;
          evd_pkg::REG_EXPECT_IS_ERROR: expect_fatal = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) deframe_word(s_tdata, s_tuser);
      if (m_tvalid && m_tready) match_result();
    end
    pending  <= expected_words.size();
    failures <= mismatches;
    checked  <= matched;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the event record deframer testbench: clock, reset, stimulus and verdict.
// Depends on evd_pkg, event_record_deframer and evd_checker.

module tb;

  localparam int QuietLimit   = 2000;
  localparam int HoldCycles   = 80;
  localparam int SettleCycles = 16;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef enum int {
    END_BETWEEN, END_IN_HEADER, END_IN_BODY, SIZE_TOO_BIG, SIZE_OVER_EXPECT, SIZE_BELOW_THREE
  } ending_t;

  // Four hand-made records: native and swapped, word 3 zero and nonzero, all-zero
  // and all-one words, and a record whose fourth word is its last.
  localparam logic [31:0] DirectedWords [19] = '{
    32'h0000_0003, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000,
    32'h0400_0000, 32'hffff_ffff, 32'h0000_0000, 32'h3412_0000, 32'hffff_ffff,
    32'h0000_0005, 32'h89ab_cdef, 32'h0123_4567, 32'h0000_ffff, 32'h0000_0000,
    32'hffff_ffff,
    32'h0300_0000, 32'h1234_5678, 32'ha5a5_a5a5, 32'h0000_0000
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [7:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int failures;
  int pending;
  int checked;

  int send_idle_pct = 14;
  int recv_idle_pct = 86;
  int hold_requests = 0;
  int words_sent = 0;
  int records_sent = 0;
  ending_t ending;

  event_record_deframer DUT (.*);

  evd_checker u_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold whenever the stimulus asks for one.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_word(input logic [31:0] w, input logic eod);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= eod;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Sends the first word_count words of a record built in host order, then byte-swapped
  // if asked. A nonzero word 3 keeps its upper half clear so that it decides the order.
  task automatic send_record(input int size, input bit swap, input bit w3_zero,
                             input int word_count);
    logic [31:0] host;
    logic [31:0] raw;
    for (int i = 0; i < word_count; i++) begin
      case (i)
        0: host = size;
        1, 2: host = $urandom;
        3: host = w3_zero ? 32'd0 : {16'd0, 16'($urandom_range(16'hffff, 1))};
        default: begin
          case ($urandom_range(7))
            0: host = '0;
            1: host = '1;
            default: host = $urandom;
          endcase
        end
      endcase
      raw = host;
      if (swap) raw = {<<8{host}};
      send_word(raw, 1'b0);
    end
    records_sent++;
  endtask

  task automatic random_records(input int word_budget, input int size_cap);
    int start;
    int size;
    start = words_sent;
    while (words_sent - start < word_budget) begin
      if ($urandom_range(7) == 0)
        size = $urandom_range(size_cap, 3);
      else
        size = $urandom_range((size_cap < 10) ? size_cap : 10, 3);
      send_record(size, 1'($urandom_range(1)), 1'($urandom_range(1)), size + 1);
    end
  endtask

  // Waits until every predicted word has left, plus a margin for held header words.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic offer_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] max_words, input logic [31:0] max_exp,
                           input logic exp_fatal, input bit poke_unused);
    if (poke_unused) offer_reg(RegUnused, $urandom);
    offer_reg(evd_pkg::REG_MAX_EVENT_WORDS, max_words);
    offer_reg(evd_pkg::REG_MAX_EXPECT, max_exp);
    // Only bit 0 of the mode register counts; the rest is noise.
    offer_reg(evd_pkg::REG_EXPECT_IS_ERROR, {31'($urandom), exp_fatal});
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int limit;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values, hand-made records.
    foreach (DirectedWords[i]) send_word(DirectedWords[i], 1'b0);
    records_sent += 4;
    settle();

    send_idle_pct = 14;
    recv_idle_pct = 86;
    configure(32'hffff_ffff, 32'd0, 1'b0, 1'b0);
    random_records(30, 40);
    settle();

    // Warning mode with a small expected size.
    send_idle_pct = 86;
    recv_idle_pct = 14;
    configure(32'd64, 32'd6, 1'b0, 1'b0);
    random_records(30, 64);
    settle();

    // Tightest size limit, widest expected limit in error mode, and a long receiver hold
    // so that the result queue fills and the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'd3, 32'hffff_ffff, 1'b1, 1'b1);
    hold_requests++;
    random_records(28, 3);
    settle();

    // The block stops for good after this, so the run ends on one such case.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ending = ending_t'($urandom_range(SIZE_BELOW_THREE, END_BETWEEN));
    case (ending)
      END_BETWEEN: begin
        configure(32'd100, 32'd0, 1'b0, 1'b0);
        send_word($urandom, 1'b1);
      end
      END_IN_HEADER: begin
        configure(32'd100, 32'd0, 1'b0, 1'b0);
        send_record(8, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3, 1));
        send_word($urandom, 1'b1);
      end
      END_IN_BODY: begin
        configure(32'd100, 32'd0, 1'b0, 1'b0);
        send_record(8, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(8, 4));
        send_word($urandom, 1'b1);
      end
      SIZE_TOO_BIG: begin
        limit = $urandom_range(20, 3);
        configure(limit, 32'd0, 1'b0, 1'b0);
        send_record(limit + $urandom_range(5, 1), 1'($urandom_range(1)),
                    1'($urandom_range(1)), limit + 2);
      end
      SIZE_OVER_EXPECT: begin
        limit = $urandom_range(10, 3);
        configure(32'd100, limit, 1'b1, 1'b0);
        send_record(limit + $urandom_range(5, 1), 1'($urandom_range(1)),
                    1'($urandom_range(1)), limit + 2);
      end
      default: begin
        configure(32'd100, $urandom_range(1), 1'b0, 1'b0);
        send_record($urandom_range(2, 0), 1'($urandom_range(1)), 1'($urandom_range(1)), 4);
      end
    endcase
    // Once stopped, every further transfer must be swallowed without a result.
    repeat (6) send_word($urandom, 1'($urandom_range(1)));
    settle();

    $display("Run covered %0d records in %0d input words with %0d results checked,",
             records_sent, words_sent, checked);
    $display("four register settings and a final stop by %s.", ending.name());
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/evd_pkg.sv
sv/event_record_deframer.sv
dv/evd_checker.sv
dv/tb.sv
